// ===== rtl/core/olid_pkg.sv =====
`timescale 1ns / 1ps

package olid_pkg;

  // Field widths fixed by the interface
  localparam int ValW = 32;
  localparam int LenW = 7;
  localparam int PosW = 7;
  localparam int CmdW = 2;
  localparam int ErrW = 2;

  // Command codes
  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_DELETE = 2'd1;
  localparam logic [CmdW-1:0] CMD_DUMP   = 2'd2;

  // Error codes
  localparam logic [ErrW-1:0] ERR_OK    = 2'd0;
  localparam logic [ErrW-1:0] ERR_RANGE = 2'd1;
  localparam logic [ErrW-1:0] ERR_FULL  = 2'd2;

  // What every cell does at each clock edge
  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_INS,
    MODE_DEL,
    MODE_ROT
  } cell_mode_t;

  // Control broadcast along the row of cells
  typedef struct packed {
    cell_mode_t      mode;
    logic [PosW-1:0] slot;
    logic [LenW-1:0] count;
    logic [ValW-1:0] value;
  } cell_bcast_t;

endpackage

// ===== rtl/core/ordered_list_insert_delete.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  cmd, position, value
// out_      output     out_valid/out_stall  item_value, is_element, last, error_code,
//                                           length, head_value, tail_value
//
// Insert, delete, unused command: the accept cycle, then a status state that loads the
// output register when it is free; the row shifts at the accept edge.
// Dump of n entries: the accept cycle, then one result per cycle while the output does
// not stall and the row rotates; a dump of an empty list gives one status result.
// Input stalls from accept until the last result is loaded, not until it leaves; an
// output stall holds the row and the sequencer. Reset empties the list, cells keep data.

module ordered_list_insert_delete
  import olid_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CmdW-1:0]        in_cmd,
  input  logic [PosW-1:0]        in_position,
  input  logic signed [ValW-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [ValW-1:0] out_item_value,
  output logic                   out_is_element,
  output logic                   out_last,
  output logic [ErrW-1:0]        out_error_code,
  output logic [LenW-1:0]        out_length,
  output logic signed [ValW-1:0] out_head_value,
  output logic signed [ValW-1:0] out_tail_value
);

  localparam logic [LenW-1:0] CapC = LenW'(CAPACITY);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STAT = 2'd1;
  localparam logic [1:0] ST_DUMP = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [LenW-1:0] count_r, count_nxt;
  logic [LenW-1:0] dcnt_r, dcnt_nxt;
  logic [ErrW-1:0] err_r, err_nxt;
  logic [ValW-1:0] hd_r, hd_nxt;
  logic [ValW-1:0] tl_r, tl_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [ValW-1:0] item_r, item_nxt;
  logic            elem_r, elem_nxt;
  logic            last_r, last_nxt;
  logic [ErrW-1:0] oerr_r, oerr_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic [ValW-1:0] head_r, head_nxt;
  logic [ValW-1:0] tail_r, tail_nxt;

  logic [ValW-1:0] cell_q [CAPACITY];
  cell_bcast_t     bcast;
  logic            accept;
  logic            out_free;
  logic            dump_last;
  logic [ErrW-1:0] op_err;
  logic [LenW-1:0] cnt_m1;
  logic [ValW-1:0] cur_head;
  logic [ValW-1:0] cur_tail;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cnt_m1   = count_r - 7'd1;
  assign dump_last = (LenW'(dcnt_r + 7'd1) == count_r);

  // Read head and tail from the row
  assign cur_head = (count_r != '0) ? cell_q[0] : '0;
  always_comb begin
    cur_tail = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      cur_tail = cur_tail | (cell_q[i] & {ValW{(LenW'(i) == cnt_m1) && (count_r != '0)}});
    end
  end

  // Check the incoming command against the current length
  always_comb begin
    op_err = ERR_OK;
    priority if (in_cmd == CMD_INSERT) begin
      if (in_position == '0 || in_position > (count_r + 7'd1)) begin
        op_err = ERR_RANGE;
      end else if (count_r >= CapC) begin
        op_err = ERR_FULL;
      end
    end else if (in_cmd == CMD_DELETE) begin
      if (in_position == '0 || in_position > count_r) begin
        op_err = ERR_RANGE;
      end
    end else begin
      op_err = ERR_OK;
    end
  end

  // Drive the row of cells
  always_comb begin
    bcast.mode  = MODE_HOLD;
    bcast.slot  = in_position - 7'd1;
    bcast.count = count_r;
    bcast.value = in_value;
    if (accept && op_err == ERR_OK && in_cmd == CMD_INSERT) begin
      bcast.mode = MODE_INS;
    end else if (accept && op_err == ERR_OK && in_cmd == CMD_DELETE) begin
      bcast.mode = MODE_DEL;
    end else if (state_r == ST_DUMP && out_free) begin
      bcast.mode = MODE_ROT;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ValW-1:0] left_w;
    logic [ValW-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_q[g+1];
    end
    olid_cell #(
      .IDX(g)
    ) u_cell (
      .clk       (clk),
      .bcast     (bcast),
      .left_data (left_w),
      .right_data(right_w),
      .wrap_data (cell_q[0]),
      .data_q    (cell_q[g])
    );
  end

  // Sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dcnt_nxt      = dcnt_r;
    err_nxt       = err_r;
    hd_nxt        = hd_r;
    tl_nxt        = tl_r;
    out_valid_nxt = out_valid_r && out_stall;
    item_nxt      = item_r;
    elem_nxt      = elem_r;
    last_nxt      = last_r;
    oerr_nxt      = oerr_r;
    len_nxt       = len_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          err_nxt   = op_err;
          state_nxt = ST_STAT;
          if (op_err == ERR_OK && in_cmd == CMD_INSERT) begin
            count_nxt = count_r + 7'd1;
          end else if (op_err == ERR_OK && in_cmd == CMD_DELETE) begin
            count_nxt = cnt_m1;
          end else if (in_cmd == CMD_DUMP && count_r != '0) begin
            state_nxt = ST_DUMP;
            dcnt_nxt  = '0;
            hd_nxt    = cur_head;
            tl_nxt    = cur_tail;
          end
        end
      end
      ST_STAT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          item_nxt      = '0;
          elem_nxt      = 1'b0;
          last_nxt      = 1'b1;
          oerr_nxt      = err_r;
          len_nxt       = count_r;
          head_nxt      = cur_head;
          tail_nxt      = cur_tail;
          state_nxt     = ST_IDLE;
        end
      end
      ST_DUMP: begin
        // Emit the head cell; the row rotates under it
        if (out_free) begin
          out_valid_nxt = 1'b1;
          item_nxt      = cell_q[0];
          elem_nxt      = 1'b1;
          last_nxt      = dump_last;
          oerr_nxt      = ERR_OK;
          len_nxt       = count_r;
          head_nxt      = hd_r;
          tail_nxt      = tl_r;
          dcnt_nxt      = dcnt_r + 7'd1;
          if (dump_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r  <= err_nxt;
    hd_r   <= hd_nxt;
    tl_r   <= tl_nxt;
    item_r <= item_nxt;
    elem_r <= elem_nxt;
    last_r <= last_nxt;
    oerr_r <= oerr_nxt;
    len_r  <= len_nxt;
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_item_value = item_r;
  assign out_is_element = elem_r;
  assign out_last       = last_r;
  assign out_error_code = oerr_r;
  assign out_length     = len_r;
  assign out_head_value = head_r;
  assign out_tail_value = tail_r;

  // Length never passes the capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CapC)
    else $error("list length above capacity");

  // The dump index stays inside the list
  a_dump_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DUMP |-> dcnt_r < count_r)
    else $error("dump index past the tail");

  // A rejected command leaves the length alone
  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && op_err != ERR_OK |=> $stable(count_r))
    else $error("rejected command changed the length");

  // The last dump result returns the sequencer to idle
  a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DUMP && out_free && dump_last |=> state_r == ST_IDLE && out_last)
    else $error("dump did not end on its last entry");

endmodule

// ===== rtl/core/olid_cell.sv =====
`timescale 1ns / 1ps

module olid_cell
  import olid_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  cell_bcast_t     bcast,
  input  logic [ValW-1:0] left_data,
  input  logic [ValW-1:0] right_data,
  input  logic [ValW-1:0] wrap_data,
  output logic [ValW-1:0] data_q
);

  localparam logic [LenW-1:0] IdxC = LenW'(IDX);

  logic [ValW-1:0] data_r;
  logic [ValW-1:0] data_nxt;

  // Pick this cell's next entry from the broadcast command
  always_comb begin
    data_nxt = data_r;
    unique case (bcast.mode)
      MODE_INS: begin
        if (IdxC == bcast.slot) begin
          data_nxt = bcast.value;
        end else if (IdxC > bcast.slot && IdxC <= bcast.count) begin
          data_nxt = left_data;
        end
      end
      MODE_DEL: begin
        if (IdxC >= bcast.slot && (IdxC + 7'd1) < bcast.count) begin
          data_nxt = right_data;
        end
      end
      MODE_ROT: begin
        if ((IdxC + 7'd1) < bcast.count) begin
          data_nxt = right_data;
        end else if ((IdxC + 7'd1) == bcast.count) begin
          data_nxt = wrap_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule
